// ===== sv/lz77bd_pkg.sv =====
`timescale 1ns / 1ps

package lz77bd_pkg;

   localparam int DIST_BITS   = 15;
   localparam int LEN_BITS    = 8;
   localparam int OUT_LANES   = 8;

   localparam int RING_DEPTH  = 32768;
   localparam int RING_AW     = $clog2(RING_DEPTH);

   localparam int DATA_W      = 8 * OUT_LANES;
   localparam int COUNT_W     = 4;
   localparam int FILL_W      = $clog2(OUT_LANES + 1);

   localparam int ACC_W       = 32;
   localparam int CNT_W       = 6;
   localparam int LIT_NEED    = 9;
   localparam int MATCH_NEED  = 1 + DIST_BITS + LEN_BITS;

   // copy length, up to 2**LEN_BITS + 2
   localparam int RUN_W       = LEN_BITS + 1;
   localparam int PROD_W      = 16;
   localparam int CMP_W       = (DIST_BITS + 1 > PROD_W) ? DIST_BITS + 1 : PROD_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LIT,
      CMD_MATCH,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [7:0]             literal;
      logic [DIST_BITS-1:0]   dist_m1;
      logic [LEN_BITS-1:0]    len_m3;
      logic                   last;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

// ===== sv/lz77bd_ram.sv =====
`timescale 1ns / 1ps

module lz77bd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lz77bd_queue.sv =====
`timescale 1ns / 1ps

module lz77bd_queue import lz77bd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head               = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== sv/lz77bd_front.sv =====
`timescale 1ns / 1ps

module lz77bd_front import lz77bd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_in_byte,
   input  logic         req_in_last,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [ACC_W-1:0]  acc_ff, acc_in, acc_cat, top, acc_rem;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_cat, need, cnt_rem;
   logic [PROD_W-1:0] prod_ff, prod_in, prod_upd;
   logic [PROD_W:0]   prod_sum, prod_add;
   logic [CMP_W-1:0]  dist_full;
   logic [RUN_W-1:0]  len_full;
   logic              accept, flag, tok, bad;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // pending bits are right-aligned; msb-align them to read the token head
   assign acc_cat = {acc_ff[ACC_W-9:0], req_in_byte};
   assign cnt_cat = cnt_ff + CNT_W'(8);
   assign top     = acc_cat << (CNT_W'(ACC_W) - cnt_cat);
   assign flag    = top[ACC_W-1];
   assign need    = flag ? CNT_W'(MATCH_NEED) : CNT_W'(LIT_NEED);
   assign tok     = (cnt_cat >= need);
   assign cnt_rem = tok ? cnt_cat - need : cnt_cat;
   assign acc_rem = acc_cat & ~({ACC_W{1'b1}} << cnt_rem);

   assign dist_full = CMP_W'(top[ACC_W-2 -: DIST_BITS]) + CMP_W'(1);
   assign len_full  = RUN_W'(top[ACC_W-2-DIST_BITS -: LEN_BITS]) + RUN_W'(3);
   assign bad       = flag && (dist_full > CMP_W'(prod_ff));

   // bytes decoded so far, saturating at the window size
   always_comb begin
      if (!flag) begin
         prod_add = (PROD_W+1)'(1);
      end else if (bad) begin
         prod_add = '0;
      end else begin
         prod_add = (PROD_W+1)'(len_full);
      end
   end
   assign prod_sum = (PROD_W+1)'(prod_ff) + prod_add;
   assign prod_upd = (prod_sum > (PROD_W+1)'(RING_DEPTH)) ? PROD_W'(RING_DEPTH)
                                                         : prod_sum[PROD_W-1:0];

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      if (accept) begin
         if (req_in_last) begin
            acc_in  = '0;
            cnt_in  = '0;
            prod_in = '0;
         end else begin
            acc_in  = acc_rem;
            cnt_in  = cnt_rem;
            prod_in = tok ? prod_upd : prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         prod_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         prod_ff <= prod_in;
      end
   end

   assign push = accept && (tok || req_in_last);

   always_comb begin
      if (!tok) begin
         push_cmd.kind = CMD_NONE;
      end else if (!flag) begin
         push_cmd.kind = CMD_LIT;
      end else if (bad) begin
         push_cmd.kind = CMD_BAD;
      end else begin
         push_cmd.kind = CMD_MATCH;
      end
      push_cmd.literal = top[ACC_W-2 -: 8];
      push_cmd.dist_m1 = top[ACC_W-2 -: DIST_BITS];
      push_cmd.len_m3  = top[ACC_W-2-DIST_BITS -: LEN_BITS];
      push_cmd.last    = req_in_last;
   end

endmodule

// ===== sv/lz77bd_back.sv =====
`timescale 1ns / 1ps

module lz77bd_back import lz77bd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  q_status_type       q_status,
   input  cmd_type            head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_out_data,
   output logic [COUNT_W-1:0] rsp_out_count,
   output logic               rsp_run_last,
   output logic               rsp_stream_end,
   output logic               rsp_bad_distance
);

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   state_type          state_ff, state_in;
   logic [RING_AW-1:0] wp_ff, wp_in, src_ff, src_in;
   logic [RUN_W-1:0]   remain_ff, remain_in;
   logic               pend_ff, pend_in, byp_ff, byp_in, last_ff, last_in;
   logic [7:0]         byp_data_ff, byp_data_in, ram_q, cur_byte;
   logic [DATA_W-1:0]  lane_data_ff, lane_data_in, base_data;
   logic [FILL_W-1:0]  lane_fill_ff, lane_fill_in, base_fill;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               run_last_ff, run_last_in;
   logic               stream_end_ff, stream_end_in;
   logic               bad_ff, bad_in;

   logic               out_free, load, flush, final_flush, room, consume, issue;
   logic               wr_en;
   logic [7:0]         wr_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a byte written in the same cycle as its read is forwarded
   assign cur_byte = byp_ff ? byp_data_ff : ram_q;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      src_in        = src_ff;
      remain_in     = remain_ff;
      pend_in       = pend_ff;
      byp_in        = byp_ff;
      byp_data_in   = byp_data_ff;
      last_in       = last_ff;
      lane_data_in  = lane_data_ff;
      lane_fill_in  = lane_fill_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      run_last_in   = run_last_ff;
      stream_end_in = stream_end_ff;
      bad_in        = bad_ff;
      load          = 1'b0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_data       = head.literal;
      flush         = 1'b0;
      final_flush   = 1'b0;
      room          = 1'b0;
      consume       = 1'b0;
      issue         = 1'b0;
      base_data     = lane_data_ff;
      base_fill     = lane_fill_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               case (head.kind)
                  CMD_MATCH: begin
                     pop          = 1'b1;
                     state_in     = ST_COPY;
                     src_in       = wp_ff - RING_AW'(head.dist_m1) - RING_AW'(1);
                     remain_in    = RUN_W'(head.len_m3) + RUN_W'(3);
                     pend_in      = 1'b0;
                     byp_in       = 1'b0;
                     last_in      = head.last;
                     lane_data_in = '0;
                     lane_fill_in = '0;
                  end
                  CMD_LIT: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        load          = 1'b1;
                        data_in       = DATA_W'(head.literal);
                        count_in      = COUNT_W'(1);
                        run_last_in   = 1'b1;
                        stream_end_in = head.last;
                        bad_in        = 1'b0;
                        wr_en         = 1'b1;
                        wp_in         = head.last ? '0 : wp_ff + RING_AW'(1);
                     end
                  end
                  CMD_BAD: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        load          = 1'b1;
                        data_in       = '0;
                        count_in      = '0;
                        run_last_in   = 1'b1;
                        stream_end_in = head.last;
                        bad_in        = 1'b1;
                        wp_in         = head.last ? '0 : wp_ff;
                     end
                  end
                  default: begin
                     // only the end of a stream with no token in its last byte
                     if (out_free) begin
                        pop           = 1'b1;
                        load          = 1'b1;
                        data_in       = '0;
                        count_in      = '0;
                        run_last_in   = 1'b1;
                        stream_end_in = head.last;
                        bad_in        = 1'b0;
                        wp_in         = head.last ? '0 : wp_ff;
                     end
                  end
               endcase
            end
         end
         ST_COPY: begin
            flush = out_free && (lane_fill_ff != '0) &&
                    ((lane_fill_ff == FILL_W'(OUT_LANES)) || (remain_ff == '0 && !pend_ff));
            final_flush = flush && (remain_ff == '0) && !pend_ff;
            room        = flush || (lane_fill_ff != FILL_W'(OUT_LANES));
            consume     = pend_ff && room;
            issue       = (remain_ff != '0) && (!pend_ff || consume);
            base_data   = flush ? '0 : lane_data_ff;
            base_fill   = flush ? '0 : lane_fill_ff;

            if (flush) begin
               load          = 1'b1;
               data_in       = lane_data_ff;
               count_in      = COUNT_W'(lane_fill_ff);
               run_last_in   = final_flush;
               stream_end_in = final_flush && last_ff;
               bad_in        = 1'b0;
            end

            lane_data_in = base_data;
            lane_fill_in = base_fill;
            if (consume) begin
               for (int i = 0; i < OUT_LANES; i++) begin
                  if (base_fill == FILL_W'(i)) begin
                     lane_data_in[8*i +: 8] = cur_byte;
                  end
               end
               lane_fill_in = base_fill + FILL_W'(1);
               wr_en        = 1'b1;
               wr_data      = cur_byte;
               wp_in        = wp_ff + RING_AW'(1);
            end

            if (issue) begin
               src_in      = src_ff + RING_AW'(1);
               remain_in   = remain_ff - RUN_W'(1);
               byp_in      = consume && (src_ff == wp_ff);
               byp_data_in = cur_byte;
            end
            pend_in = issue || (pend_ff && !consume);

            if (final_flush) begin
               state_in = ST_IDLE;
               if (last_ff) begin
                  wp_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pend_ff      <= 1'b0;
         byp_ff       <= 1'b0;
         lane_fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pend_ff      <= pend_in;
         byp_ff       <= byp_in;
         lane_fill_ff <= lane_fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff        <= src_in;
      remain_ff     <= remain_in;
      byp_data_ff   <= byp_data_in;
      last_ff       <= last_in;
      lane_data_ff  <= lane_data_in;
      data_ff       <= data_in;
      count_ff      <= count_in;
      run_last_ff   <= run_last_in;
      stream_end_ff <= stream_end_in;
      bad_ff        <= bad_in;
   end

   lz77bd_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (src_ff),
      .rd_data (ram_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_data     = data_ff;
   assign rsp_out_count    = count_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_stream_end   = stream_end_ff;
   assign rsp_bad_distance = bad_ff;

endmodule

// ===== sv/lz77_bit_packed_decoder_core.sv =====
`timescale 1ns / 1ps

// channel | ports                                   | transfer when
// --------+-----------------------------------------+----------------------------
// request | req_valid req_stall req_in_byte/in_last | req_valid && !req_stall
// result  | rsp_valid rsp_stall rsp_out_* rsp_run_* | rsp_valid && !rsp_stall
//         |          rsp_stream_end rsp_bad_distance|
//
// a byte is parsed in the cycle it is taken; at most one token ends per byte.
// literal, bad distance, empty end: queued, then loaded into the result register.
// a match copies one byte per cycle through the ring port unless the result stalls.
// a two-entry command queue lets bytes keep arriving while a match is copied.
// synchronous reset clears the bit accumulator, queue and copy engine; the
// history ring is not cleared, as only bytes of the current stream are read.

module lz77_bit_packed_decoder_core import lz77bd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_out_data,
   output logic [COUNT_W-1:0] rsp_out_count,
   output logic               rsp_run_last,
   output logic               rsp_stream_end,
   output logic               rsp_bad_distance
);

   q_status_type q_status;
   cmd_type      push_cmd, head;
   logic         push, pop;

   lz77bd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lz77bd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   lz77bd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_data     (rsp_out_data),
      .rsp_out_count    (rsp_out_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_end   (rsp_stream_end),
      .rsp_bad_distance (rsp_bad_distance)
   );

endmodule

// ===== sv/lz77bd_checker.sv =====
`timescale 1ns / 1ps

module lz77bd_checker import lz77bd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_in_byte,
   input logic               req_in_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [DATA_W-1:0]  rsp_out_data,
   input logic [COUNT_W-1:0] rsp_out_count,
   input logic               rsp_run_last,
   input logic               rsp_stream_end,
   input logic               rsp_bad_distance
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_data) &&
         $stable(rsp_out_count) && $stable(rsp_run_last) && $stable(rsp_stream_end) &&
         $stable(rsp_bad_distance))
      else $error("result changed while stalled");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run last");

   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_distance |-> rsp_out_count == '0 && rsp_out_data == '0)
      else $error("bad distance result carries data");

   // only the closing transfer of a token may be a partial group
   a_full_lanes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_count == COUNT_W'(OUT_LANES))
      else $error("partial result before the end of a token");

   a_empty_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_count == '0 && !rsp_bad_distance |-> rsp_stream_end)
      else $error("empty result outside stream end");

endmodule

bind lz77_bit_packed_decoder_core lz77bd_checker u_checker (.*);
